FILE: hdl/allt_pkg.sv
// Package for the linked list table: field widths, operation codes and cell types.
package allt_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 32;
  localparam int TAG_W  = 64;

  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd2;

  // One stored list entry, held by one cell
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Command token that walks the chain, one cell per cycle
  typedef struct packed {
    logic              active;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic              hit;    // add placed, delete removed, or find matched
    logic              shift;  // delete done upstream, compacting the tail
  } tok_t;

endpackage

FILE: hdl/allt_cmd_if.sv
// Command channel: operation, key and tag with valid/ready handshake.
interface allt_cmd_if;
  import allt_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [TAG_W-1:0]  tag;

  modport source (output valid, func, key, tag, input ready);
  modport sink   (input valid, func, key, tag, output ready);
endinterface

FILE: hdl/allt_rsp_if.sv
// Result channel: success and list-empty flags with valid/ready handshake.
interface allt_rsp_if;
  logic valid;
  logic ready;
  logic success;
  logic list_empty;

  modport source (output valid, success, list_empty, input ready);
  modport sink   (input valid, success, list_empty, output ready);
endinterface

FILE: hdl/array_linked_list_table_core.sv
// An accepted command is registered as the head token, passes each cell's token register and
// then loads the result register; the token visits SLOTS-1 cells, one command at a time.
// The list is kept compacted in cell order, so cell order is list order from the head.
// Reset clears every cell's valid bit: the list is empty and all slots free.
// No clearing pass; commands are accepted in the first cycle after reset.
// Top level: command sequencer, chain of list cells and result register.
module array_linked_list_table_core #(
  parameter int SLOTS = allt_pkg::SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  allt_cmd_if.sink   cmd,
  allt_rsp_if.source rsp
);
  import allt_pkg::*;

  localparam int CELLS = SLOTS - 1;

  tok_t   tok  [CELLS+1];
  entry_t ent  [CELLS];
  logic   pull [CELLS];

  tok_t tok_head;
  logic inflight;
  logic accept;

  assign cmd.ready = !inflight && (!rsp.valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  // Token injection at the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head <= '0;
    end else if (accept) begin
      tok_head.active <= 1'b1;
      tok_head.func   <= cmd.func;
      tok_head.key    <= cmd.key;
      tok_head.tag    <= cmd.tag;
      tok_head.hit    <= 1'b0;
      tok_head.shift  <= 1'b0;
    end else begin
      tok_head.active <= 1'b0;
    end
  end

  assign tok[0] = tok_head;

  // Cell chain
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    entry_t r_ent;
    logic   r_pull;
    if (k < CELLS - 1) begin : g_mid
      assign r_ent  = ent[k+1];
      assign r_pull = pull[k+1];
    end else begin : g_last
      assign r_ent  = '0;
      assign r_pull = 1'b0;
    end
    allt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[k]),
      .tok_out    (tok[k+1]),
      .right_ent  (r_ent),
      .right_pull (r_pull),
      .ent        (ent[k]),
      .pull       (pull[k])
    );
  end

  // Busy flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        inflight <= 1'b1;
      end else if (tok[CELLS].active) begin
        inflight <= 1'b0;
      end
      if (tok[CELLS].active) begin
        rsp.valid      <= 1'b1;
        rsp.success    <= tok[CELLS].hit;
        rsp.list_empty <= !ent[0].valid;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end
endmodule

FILE: hdl/allt_cell.sv
// One list cell: holds one entry and acts on the command token passing through.
module allt_cell (
  input  logic            clk,
  input  logic            rst,
  input  allt_pkg::tok_t   tok_in,
  output allt_pkg::tok_t   tok_out,
  input  allt_pkg::entry_t right_ent,
  input  logic            right_pull,
  output allt_pkg::entry_t ent,
  output logic            pull
);
  import allt_pkg::*;

  tok_t tok_next;
  logic match;
  logic store;
  logic clear;

  assign match = ent.valid && (ent.key == tok_in.key);

  // Token action at this cell
  always_comb begin
    tok_next = tok_in;
    store    = 1'b0;
    clear    = 1'b0;
    pull     = 1'b0;
    if (tok_in.active) begin
      case (tok_in.func)
        FUNC_ADD: begin
          // entries form a prefix, so the first empty cell is the tail
          if (!tok_in.hit && !ent.valid) begin
            store        = 1'b1;
            tok_next.hit = 1'b1;
          end
        end
        FUNC_DEL: begin
          if (tok_in.shift) begin
            // move this entry one cell toward the head
            pull  = 1'b1;
            clear = 1'b1;
          end else if (!tok_in.hit && match) begin
            clear          = 1'b1;
            tok_next.hit   = 1'b1;
            tok_next.shift = 1'b1;
          end
        end
        FUNC_FIND: begin
          if (match) begin
            tok_next.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Entry storage and token hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      tok_out   <= '0;
    end else begin
      if (right_pull) begin
        ent <= right_ent;
      end else if (store) begin
        ent.valid <= 1'b1;
        ent.key   <= tok_in.key;
        ent.tag   <= tok_in.tag;
      end else if (clear) begin
        ent.valid <= 1'b0;
      end
      tok_out <= tok_next;
    end
  end
endmodule
